// ===== rtl/aeske_pkg.sv =====
// Package with AES key expansion constants, S-box and round constants.
package aeske_pkg;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned IDX_W = 6;
	localparam int unsigned WIN_DEPTH = 8;
	localparam int unsigned WIN_AW = 3;

	localparam logic [1:0] KEY_128 = 2'd0;
	localparam logic [1:0] KEY_192 = 2'd1;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] r;
		case (a)
			8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
			8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
			8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
			8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
			8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
			8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
			8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
			8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
			8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
			8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
			8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
			8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
			8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
			8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
			8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
			8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
			8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
			8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
			8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
			8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
			8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
			8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
			8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
			8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
			8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
			8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
			8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
			8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
			8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
			8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
			8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
			8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
			8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
			8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
			8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
			8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
			8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
			8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
			8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
			8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
			8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
			8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
			8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
			8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
			8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
			8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
			8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
			8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
			8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
			8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
			8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
			8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
			8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
			8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
			8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
			8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
			8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
			8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
			8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
			8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
			8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
			8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
			8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
			8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] v);
		return {sbox(v[31:24]), sbox(v[23:16]), sbox(v[15:8]), sbox(v[7:0])};
	endfunction

	function automatic logic [7:0] next_rcon(input logic [7:0] rc);
		return rc[7] ? {rc[6:0], 1'b0} ^ 8'h1b : {rc[6:0], 1'b0};
	endfunction
endpackage

// ===== rtl/aes_key_expansion_core.sv =====
// AES key expansion core for 128-, 192- and 256-bit keys with a word memory.
//
// Write key_size while idle, then present key words one per start transaction,
// first key byte in bits 31:24. After the last key word (4, 6 or 8) the core
// reads the key back from its 8-entry window memory and emits the whole
// schedule (44, 52 or 60 words) on schedule_word with strobe, one word per
// cycle after a priming state that does the first memory read.
// Busy goes high once the final key word is taken and stays high through the
// priming state and the generation of every schedule word.
// The last word is shown, with last_word, in the first cycle in which busy is low.
// The receiver cannot stall: every strobed word must be taken when shown.
// The window holds the last Nk generated words; w[i-Nk] is read ahead through
// the registered read port and the new word is written back into its slot.
module aes_key_expansion_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] key_word,
	output logic        strobe,
	output logic [31:0] schedule_word,
	output logic [5:0]  word_index,
	output logic        last_word
);
	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_PRIME = 2'd1;
	localparam logic [1:0] ST_GEN = 2'd2;

	logic [31:0] win_mem [aeske_pkg::WIN_DEPTH];
	logic [31:0] rd_data_q;
	logic [2:0]  rd_addr;
	logic        mem_we;
	logic [2:0]  wr_addr;
	logic [31:0] wr_data;

	logic [1:0]  key_size_q;
	logic [1:0]  state_q;
	logic [3:0]  loaded_q;
	logic [5:0]  idx_q;
	logic [31:0] prev_q;
	logic [2:0]  pos_q;
	logic [7:0]  rcon_q;

	logic [3:0]  nk;
	logic [5:0]  total;
	logic [31:0] temp;
	logic [31:0] new_word;
	logic [2:0]  pos_next;

	always_comb begin
		case (key_size_q)
			aeske_pkg::KEY_128: begin nk = 4'd4; total = 6'd43; end
			aeske_pkg::KEY_192: begin nk = 4'd6; total = 6'd51; end
			default: begin nk = 4'd8; total = 6'd59; end
		endcase
	end

	always_comb begin
		if (pos_q == 3'd0) begin
			temp = aeske_pkg::sub_word({prev_q[23:0], prev_q[31:24]}) ^ {rcon_q, 24'd0};
		end else if (nk == 4'd8 && pos_q == 3'd4) begin
			temp = aeske_pkg::sub_word(prev_q);
		end else begin
			temp = prev_q;
		end
	end

	// Key words pass straight through; later words use the recurrence.
	assign new_word = (idx_q < {2'd0, nk}) ? rd_data_q : (rd_data_q ^ temp);
	assign pos_next = ({1'b0, pos_q} == nk - 4'd1) ? 3'd0 : pos_q + 3'd1;

	always_comb begin
		mem_we = 1'b0;
		wr_addr = loaded_q[2:0];
		wr_data = key_word;
		rd_addr = 3'd0;
		if (state_q == ST_LOAD) begin
			mem_we = start;
		end else if (state_q == ST_GEN) begin
			mem_we = idx_q >= {2'd0, nk};
			wr_addr = pos_q;
			wr_data = new_word;
			rd_addr = pos_next;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			win_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= win_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= 2'd0;
			state_q <= ST_LOAD;
			loaded_q <= 4'd0;
			idx_q <= 6'd0;
			pos_q <= 3'd0;
			rcon_q <= 8'h01;
			prev_q <= 32'd0;
			strobe <= 1'b0;
			last_word <= 1'b0;
			word_index <= 6'd0;
			schedule_word <= 32'd0;
		end else begin
			strobe <= 1'b0;
			last_word <= 1'b0;
			if (cfg_we) begin
				key_size_q <= cfg_wdata;
				loaded_q <= 4'd0;
			end
			case (state_q)
				ST_LOAD: begin
					if (start) begin
						if (loaded_q + 4'd1 >= nk) begin
							loaded_q <= 4'd0;
							state_q <= ST_PRIME;
						end else begin
							loaded_q <= loaded_q + 4'd1;
						end
					end
				end
				ST_PRIME: begin
					idx_q <= 6'd0;
					pos_q <= 3'd0;
					rcon_q <= 8'h01;
					state_q <= ST_GEN;
				end
				ST_GEN: begin
					strobe <= 1'b1;
					word_index <= idx_q;
					schedule_word <= new_word;
					prev_q <= new_word;
					pos_q <= pos_next;
					if (pos_q == 3'd0 && idx_q >= {2'd0, nk}) begin
						rcon_q <= aeske_pkg::next_rcon(rcon_q);
					end
					if (idx_q == total) begin
						last_word <= 1'b1;
						state_q <= ST_LOAD;
					end
					idx_q <= idx_q + 6'd1;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign busy = state_q != ST_LOAD;
endmodule
